>>> rtl/core/ffp_pkg.sv
// ----------------------------------------------------------------------------
// ffp_pkg
// Shared types and constants for the fern posterior train unit.
// ----------------------------------------------------------------------------
package ffp_pkg;
    localparam int unsigned MAX_FERNS  = 10;
    localparam int unsigned CODE_W     = 13;
    localparam int unsigned CONF_W     = 20;
    localparam int unsigned COUNT_W    = 16;
    localparam int unsigned WEIGHT_W   = 17;
    localparam int unsigned CFG_IDX_W  = 1;
    localparam int unsigned CFG_DATA_W = 20;

    localparam logic [CFG_IDX_W-1:0] CFG_POS_THR = 1'd0;
    localparam logic [CFG_IDX_W-1:0] CFG_NEG_THR = 1'd1;

    localparam logic [CONF_W-1:0] THR_RESET = 20'd327680;
    localparam logic [COUNT_W-1:0] COUNT_MAX = 16'hFFFF;

    typedef struct packed {
        logic                            operation;
        logic                            label;
        logic [MAX_FERNS-1:0][CODE_W-1:0] leaf_code;
    } t_in_beat;

    typedef struct packed {
        logic [CONF_W-1:0] confidence;
        logic              updated;
    } t_out_beat;

    // Lane control: read strobe, learn strobe, sample polarity
    typedef struct packed {
        logic rd;
        logic learn;
        logic positive;
    } t_lane_ctl;
endpackage

>>> rtl/core/ffp_stream_if.sv
// ----------------------------------------------------------------------------
// ffp_stream_if
// Valid/ready channel carrying one payload beat.
// ----------------------------------------------------------------------------
interface ffp_stream_if #(
    parameter type T = logic
);
    logic valid;
    logic ready;
    T     data;

    modport source (output valid, output data, input ready);
    modport sink   (input valid, input data, output ready);
endinterface

>>> rtl/core/fern_forest_posterior_train_unit.sv
// An item passes the states READ, MERGE, SUM, DEC, WAIT and OUT; with learning,
// WAIT also holds it while the lanes run an increment and a 17-bit serial divide.
// No new item is taken until the last one has reached the output register; a result
// left waiting at the output holds the next item before its result stage.
// Reset: a clearing pass over all 2^FEATURE_BITS leaves zeroes all counts and
// weights; no item is accepted until it ends. Thresholds reset to 5.0.
// ----------------------------------------------------------------------------
// fern_forest_posterior_train_unit
// Per-fern lanes look up leaf weights, a merge stage sums the confidence,
// and misclassified training samples update counts and weights.
// ----------------------------------------------------------------------------
module fern_forest_posterior_train_unit #(
    parameter int unsigned TREES        = 10,
    parameter int unsigned FEATURE_BITS = 13
) (
    input  logic                             i_clk,
    input  logic                             i_rst_n,
    input  logic                             i_cfg_we,
    input  logic [ffp_pkg::CFG_IDX_W-1:0]    i_cfg_idx,
    input  logic [ffp_pkg::CFG_DATA_W-1:0]   i_cfg_data,
    ffp_stream_if.sink                       s_in,
    ffp_stream_if.source                     m_out
);
    localparam logic [2:0] ST_CLEAR = 3'd0;
    localparam logic [2:0] ST_IDLE  = 3'd1;
    localparam logic [2:0] ST_READ  = 3'd2;
    localparam logic [2:0] ST_SUM   = 3'd3;
    localparam logic [2:0] ST_DEC   = 3'd4;
    localparam logic [2:0] ST_WAIT  = 3'd5;
    localparam logic [2:0] ST_OUT   = 3'd6;
    localparam logic [2:0] ST_MERGE = 3'd7;

    logic [2:0]                       r_state, n_state;
    logic [FEATURE_BITS:0]            r_clr;
    logic [ffp_pkg::CONF_W-1:0]       r_pos_thr, r_neg_thr;
    logic                             r_op, r_label, r_learn;
    logic [ffp_pkg::CONF_W-1:0]       r_conf;
    logic [TREES-1:0][FEATURE_BITS-1:0] r_addr;
    logic [TREES-1:0][ffp_pkg::WEIGHT_W-1:0] weights;
    logic [TREES-1:0]                 busy;
    logic [ffp_pkg::CONF_W-1:0]       sum;
    ffp_pkg::t_lane_ctl               ctl;
    ffp_pkg::t_in_beat                in_b;
    ffp_pkg::t_out_beat               r_out;
    logic                             r_out_v;
    logic                             learn_now;

    assign in_b = s_in.data;

    // Configuration writes
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_pos_thr <= ffp_pkg::THR_RESET;
            r_neg_thr <= ffp_pkg::THR_RESET;
        end else if (i_cfg_we) begin
            unique case (i_cfg_idx)
                ffp_pkg::CFG_POS_THR: r_pos_thr <= i_cfg_data;
                ffp_pkg::CFG_NEG_THR: r_neg_thr <= i_cfg_data;
                default: ;
            endcase
        end
    end

    assign s_in.ready = (r_state == ST_IDLE);
    assign learn_now  = r_op && (r_label ? (r_conf <= r_pos_thr) : (r_conf >= r_neg_thr));

    assign ctl.rd       = (r_state == ST_READ);
    assign ctl.learn    = (r_state == ST_DEC) && learn_now;
    assign ctl.positive = r_label;

    // Fern lanes
    for (genvar t = 0; t < TREES; t++) begin : g_lane
        ffp_lane #(.FEATURE_BITS(FEATURE_BITS)) u_lane (
            .i_clk      (i_clk),
            .i_rst_n    (i_rst_n),
            .i_addr     (r_addr[t]),
            .i_ctl      (ctl),
            .i_clr_en   (r_state == ST_CLEAR),
            .i_clr_addr (r_clr[FEATURE_BITS-1:0]),
            .o_weight   (weights[t]),
            .o_busy     (busy[t])
        );
    end

    ffp_merge #(.TREES(TREES)) u_merge (
        .i_clk    (i_clk),
        .i_weight (weights),
        .o_sum    (sum)
    );

    // Sequencer: clear, read leaves, merge registers sum, capture, decide, output
    always_comb begin
        n_state = r_state;
        unique case (r_state)
            ST_CLEAR: if (r_clr[FEATURE_BITS]) n_state = ST_IDLE;
            ST_IDLE:  if (s_in.valid) n_state = ST_READ;
            ST_READ:  n_state = ST_MERGE;
            ST_MERGE: n_state = ST_SUM;
            ST_SUM:   n_state = ST_DEC;
            ST_DEC:   n_state = ST_WAIT;
            ST_WAIT:  if (busy == '0 && !r_out_v) n_state = ST_OUT;
            ST_OUT:   n_state = ST_IDLE;
            default:  n_state = ST_IDLE;
        endcase
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= ST_CLEAR;
            r_clr   <= '0;
            r_out_v <= 1'b0;
        end else begin
            r_state <= n_state;
            if (r_state == ST_CLEAR) r_clr <= r_clr + 1'b1;
            if (r_state == ST_OUT) r_out_v <= 1'b1;
            else if (m_out.ready) r_out_v <= 1'b0;
        end
        if (s_in.valid && s_in.ready) begin
            r_op    <= in_b.operation;
            r_label <= in_b.label;
            for (int t = 0; t < TREES; t++) begin
                r_addr[t] <= FEATURE_BITS'(in_b.leaf_code[t]);
            end
        end
        if (r_state == ST_SUM) r_conf <= sum;
        if (r_state == ST_DEC) r_learn <= learn_now;
        if (r_state == ST_OUT) begin
            r_out.confidence <= r_conf;
            r_out.updated    <= r_learn;
        end
    end

    assign m_out.valid = r_out_v;
    assign m_out.data  = r_out;

    // No item accepted during the clearing pass
    a_no_accept_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_CLEAR |-> !s_in.ready)
        else $error("accept during clear");
    // Lanes agree on busy
    a_lane_sync: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        busy == '0 || busy == '1)
        else $error("lanes out of step");
    // Result only loaded when the output register is free
    a_out_free: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_state == ST_OUT |-> !r_out_v)
        else $error("result overwritten");
endmodule

>>> rtl/core/ffp_lane.sv
// ----------------------------------------------------------------------------
// ffp_lane
// One fern: count/weight memories, read of the addressed leaf, and a
// learning update with a bit-serial restoring divider for the new weight.
// ----------------------------------------------------------------------------
module ffp_lane #(
    parameter int unsigned FEATURE_BITS = 13
) (
    input  logic                           i_clk,
    input  logic                           i_rst_n,
    input  logic [FEATURE_BITS-1:0]        i_addr,
    input  ffp_pkg::t_lane_ctl             i_ctl,
    input  logic                           i_clr_en,
    input  logic [FEATURE_BITS-1:0]        i_clr_addr,
    output logic [ffp_pkg::WEIGHT_W-1:0]   o_weight,
    output logic                           o_busy
);
    localparam int unsigned LEAVES = 1 << FEATURE_BITS;
    localparam int unsigned DIV_N  = ffp_pkg::WEIGHT_W;
    localparam int unsigned SUM_W  = ffp_pkg::COUNT_W + 1;
    localparam int unsigned CNT_W  = $clog2(DIV_N + 1);

    logic [ffp_pkg::COUNT_W-1:0]  mem_pos [LEAVES];
    logic [ffp_pkg::COUNT_W-1:0]  mem_neg [LEAVES];
    logic [ffp_pkg::WEIGHT_W-1:0] mem_w   [LEAVES];

    logic [ffp_pkg::COUNT_W-1:0] r_pos, r_neg;
    logic [FEATURE_BITS-1:0]     r_addr;
    logic [1:0]                  r_phase, n_phase;
    logic [ffp_pkg::COUNT_W-1:0] r_p, n_p;
    logic [SUM_W-1:0]            r_den, n_den;
    logic [SUM_W:0]              r_rem, n_rem;
    logic [DIV_N-1:0]            r_quo, n_quo;
    logic [CNT_W-1:0]            r_cnt, n_cnt;
    logic                        r_positive, n_positive;
    logic                        wr_en;
    logic [ffp_pkg::COUNT_W-1:0] wr_p, wr_n;
    logic [ffp_pkg::WEIGHT_W-1:0] wr_w;
    logic [SUM_W:0]              shl, diff;

    localparam logic [1:0] PH_IDLE = 2'd0;
    localparam logic [1:0] PH_INC  = 2'd1;
    localparam logic [1:0] PH_DIV  = 2'd2;

    // Read the addressed leaf, write the update or clear
    always_ff @(posedge i_clk) begin
        if (i_ctl.rd) begin
            o_weight <= mem_w[i_addr];
            r_pos    <= mem_pos[i_addr];
            r_neg    <= mem_neg[i_addr];
            r_addr   <= i_addr;
        end
        if (i_clr_en) begin
            mem_pos[i_clr_addr] <= '0;
            mem_neg[i_clr_addr] <= '0;
            mem_w[i_clr_addr]   <= '0;
        end else if (wr_en) begin
            mem_pos[r_addr] <= wr_p;
            mem_neg[r_addr] <= wr_n;
            mem_w[r_addr]   <= wr_w;
        end
    end

    assign shl  = {r_rem[SUM_W-1:0], r_quo[DIV_N-1]};
    assign diff = shl - {1'b0, r_den};

    // Increment, then divide one quotient bit per cycle
    always_comb begin
        n_phase    = r_phase;
        n_p        = r_p;
        n_den      = r_den;
        n_rem      = r_rem;
        n_quo      = r_quo;
        n_cnt      = r_cnt;
        n_positive = r_positive;
        wr_en      = 1'b0;
        wr_p       = r_p;
        wr_n       = r_den[ffp_pkg::COUNT_W-1:0] - r_p;
        wr_w       = r_quo;
        unique case (r_phase)
            PH_IDLE: begin
                if (i_ctl.learn) begin
                    n_phase    = PH_INC;
                    n_positive = i_ctl.positive;
                end
            end
            PH_INC: begin
                logic [ffp_pkg::COUNT_W-1:0] p, n;
                p = r_pos;
                n = r_neg;
                if (r_positive) begin
                    if (p != ffp_pkg::COUNT_MAX) p = p + 1'b1;
                end else begin
                    if (n != ffp_pkg::COUNT_MAX) n = n + 1'b1;
                end
                n_p   = p;
                n_den = {1'b0, p} + {1'b0, n};
                // Dividend is p << 16; its top 15 bits give no quotient bits
                // since p <= p + n, so start with them already in the remainder
                n_rem = {{(SUM_W + 2 - ffp_pkg::COUNT_W){1'b0}}, p[ffp_pkg::COUNT_W-1:1]};
                n_quo = {p[0], {(DIV_N - 1){1'b0}}};
                n_cnt = '0;
                n_phase = PH_DIV;
            end
            PH_DIV: begin
                if (diff[SUM_W] == 1'b0) begin
                    n_rem = diff;
                    n_quo = {r_quo[DIV_N-2:0], 1'b1};
                end else begin
                    n_rem = shl;
                    n_quo = {r_quo[DIV_N-2:0], 1'b0};
                end
                n_cnt = r_cnt + 1'b1;
                if (r_cnt == CNT_W'(DIV_N - 1)) begin
                    n_phase = PH_IDLE;
                end
            end
            default: n_phase = PH_IDLE;
        endcase
        if (r_phase == PH_DIV && r_cnt == CNT_W'(DIV_N - 1)) begin
            wr_en = 1'b1;
            wr_w  = (r_p == '0) ? '0 : n_quo;
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_phase <= PH_IDLE;
        end else begin
            r_phase <= n_phase;
        end
        r_p        <= n_p;
        r_den      <= n_den;
        r_rem      <= n_rem;
        r_quo      <= n_quo;
        r_cnt      <= n_cnt;
        r_positive <= n_positive;
    end

    assign o_busy = (r_phase != PH_IDLE);

    // Weight never exceeds one in Q16
    a_weight_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        wr_en |-> wr_w <= ffp_pkg::WEIGHT_W'(65536))
        else $error("leaf weight above one");
    // Learning only starts from idle
    a_learn_idle: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        i_ctl.learn |-> r_phase == PH_IDLE)
        else $error("learn while dividing");
    // Divider counter stays in range
    a_cnt_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_phase == PH_DIV |-> r_cnt < CNT_W'(DIV_N))
        else $error("divider count overrun");
endmodule

>>> rtl/core/ffp_merge.sv
// ----------------------------------------------------------------------------
// ffp_merge
// Registered sum of the lane weights into the Q16 confidence.
// ----------------------------------------------------------------------------
module ffp_merge #(
    parameter int unsigned TREES = 10
) (
    input  logic                                    i_clk,
    input  logic [TREES-1:0][ffp_pkg::WEIGHT_W-1:0] i_weight,
    output logic [ffp_pkg::CONF_W-1:0]              o_sum
);
    logic [ffp_pkg::CONF_W-1:0] n_sum;

    // Add the lane weights
    always_comb begin
        n_sum = '0;
        for (int t = 0; t < TREES; t++) begin
            n_sum = n_sum + ffp_pkg::CONF_W'(i_weight[t]);
        end
    end

    always_ff @(posedge i_clk) begin
        o_sum <= n_sum;
    end
endmodule
